// ===== hdl/bright_spot_centroid_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Bright spot centroid tracker: assertion macros
// Shared property forms for the port-level checker of the tracker.
// ----------------------------------------------------------------------------
`ifndef BRIGHT_SPOT_CENTROID_TRACKER_DEFINES_SVH
`define BRIGHT_SPOT_CENTROID_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSCT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bsct_pkg.sv =====
// ----------------------------------------------------------------------------
// Bright spot centroid tracker package
// Configuration and result types, register indexes, reset values and the
// back-end state encoding.
// ----------------------------------------------------------------------------
package bsct_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LUMA_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_MIN_MASS       = 3'd1;
    localparam logic [2:0] CFG_FRAME_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_SLICE_HEIGHT   = 3'd3;
    localparam logic [2:0] CFG_PADDLE_RANGE   = 3'd4;
    localparam logic [2:0] CFG_EMA_ALPHA      = 3'd5;
    localparam logic [2:0] CFG_MOTION_THRESH  = 3'd6;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 23;

    // Register values after reset.
    localparam logic [7:0]  RST_LUMA_THRESHOLD = 8'd200;
    localparam logic [22:0] RST_MIN_MASS       = 23'd50;
    localparam logic [8:0]  RST_FRAME_WIDTH    = 9'd160;
    localparam logic [6:0]  RST_SLICE_HEIGHT   = 7'd40;
    localparam logic [9:0]  RST_PADDLE_RANGE   = 10'd200;
    localparam logic [8:0]  RST_EMA_ALPHA      = 9'd90;
    localparam logic [13:0] RST_MOTION_THRESH  = 14'd460;

    // Smoothed paddle position after reset: half the reset range, Q8.
    localparam logic [17:0] RST_SMOOTHED_POS = 18'd25600;

    // Unity weight and rounding offset of the Q8 smoothing filter.
    localparam logic [8:0] ALPHA_ONE  = 9'd256;
    localparam int         Q8_ROUND   = 128;

    // Largest mass that the result field can report.
    localparam logic [22:0] MASS_SAT = 23'h7FFFFF;

    // Stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_BITS    = 81;
    localparam int OUT_TDATA_W = 88;

    typedef struct packed {
        logic [7:0]  luma_threshold;
        logic [22:0] min_mass;
        logic [8:0]  frame_width;
        logic [6:0]  slice_height;
        logic [9:0]  paddle_range;
        logic [8:0]  ema_alpha_q8;
        logic [13:0] motion_threshold_q8;
    } cfg_t;

    typedef struct packed {
        logic        motion;
        logic [17:0] paddle_pos_q8;
        logic [7:0]  brightest_luma;
        logic [22:0] slice_mass;
        logic [13:0] centroid_row_q8;
        logic [15:0] centroid_col_q8;
        logic        detected;
    } result_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CHECK,
        BK_DIV_COL,
        BK_DIV_ROW,
        BK_TGT_MUL,
        BK_TGT_START,
        BK_DIV_TGT,
        BK_EMA_MUL,
        BK_EMA_SUM,
        BK_DONE
    } back_state_t;

endpackage

// ===== hdl/bsct_queue.sv =====
// ----------------------------------------------------------------------------
// Slice queue
// Small register FIFO holding finished slice sums between the pixel front
// end and the division back end.
// ----------------------------------------------------------------------------
module bsct_queue #(
    parameter int WIDTH = 91,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/bsct_divider.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsct_divider #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;

    assign done = done_reg;
    assign quo  = quo_reg;

    // One restoring step: bring down the next numerator bit and try a subtract.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W+1])
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

// ===== hdl/bsct_front.sv =====
// ----------------------------------------------------------------------------
// Pixel front end
// Counts columns and rows, accumulates weighted sums, mass and peak luma,
// and hands the sums of a finished slice to the queue.
// ----------------------------------------------------------------------------
module bsct_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 64,
    parameter int WID_W      = 9,
    parameter int HGT_W      = 7,
    parameter int MASS_W     = 23,
    parameter int CSUM_W     = 31,
    parameter int RSUM_W     = 29
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         luma_threshold,
    input  logic [WID_W-1:0]   width_eff,
    input  logic [HGT_W-1:0]   height_eff,
    input  logic               accept,
    input  logic [7:0]         luma,
    input  logic               frame_start,
    output logic               push,
    output logic [CSUM_W-1:0]  push_col_sum,
    output logic [RSUM_W-1:0]  push_row_sum,
    output logic [MASS_W-1:0]  push_mass,
    output logic [7:0]         push_peak
);
    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PC_W = CW + 9;
    localparam int PR_W = RW + 9;

    logic [CW-1:0]     col_count_reg, col_count_next;
    logic [RW-1:0]     row_count_reg, row_count_next;
    logic [CSUM_W-1:0] col_sum_reg, col_sum_next;
    logic [RSUM_W-1:0] row_sum_reg, row_sum_next;
    logic [MASS_W-1:0] mass_reg, mass_next;
    logic [7:0]        peak_reg, peak_next;

    logic [CW-1:0]     col_base, col_eff;
    logic [RW-1:0]     row_base, row_eff;
    logic [CSUM_W-1:0] col_sum_base, col_sum_new;
    logic [RSUM_W-1:0] row_sum_base, row_sum_new;
    logic [MASS_W-1:0] mass_base, mass_new;
    logic [7:0]        peak_base, peak_new;
    logic [8:0]        weight;
    logic [PC_W-1:0]   col_prod;
    logic [PR_W-1:0]   row_prod;
    logic              col_end;
    logic              row_end;
    logic              last;

    assign push         = accept && last;
    assign push_col_sum = col_sum_new;
    assign push_row_sum = row_sum_new;
    assign push_mass    = mass_new;
    assign push_peak    = peak_new;

    // Accumulation for the current pixel; a slice start begins from zero.
    always_comb
    begin
        col_base     = frame_start ? '0 : col_count_reg;
        row_base     = frame_start ? '0 : row_count_reg;
        col_sum_base = frame_start ? '0 : col_sum_reg;
        row_sum_base = frame_start ? '0 : row_sum_reg;
        mass_base    = frame_start ? '0 : mass_reg;
        peak_base    = frame_start ? '0 : peak_reg;

        // Counters left beyond a shrunken frame restart at zero.
        col_eff = (WID_W'(col_base) >= width_eff) ? '0 : col_base;
        row_eff = (HGT_W'(row_base) >= height_eff) ? '0 : row_base;

        if (luma >= luma_threshold)
        begin
            weight = {1'b0, luma} - {1'b0, luma_threshold} + 9'd1;
        end
        else
        begin
            weight = 9'd0;
        end

        col_prod    = PC_W'(col_eff) * PC_W'(weight);
        row_prod    = PR_W'(row_eff) * PR_W'(weight);
        col_sum_new = col_sum_base + CSUM_W'(col_prod);
        row_sum_new = row_sum_base + RSUM_W'(row_prod);
        mass_new    = mass_base + MASS_W'(weight);
        peak_new    = (luma > peak_base) ? luma : peak_base;

        col_end = (WID_W'(col_eff) == width_eff - WID_W'(1));
        row_end = (HGT_W'(row_eff) == height_eff - HGT_W'(1));
        last    = col_end && row_end;

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        col_sum_next   = col_sum_reg;
        row_sum_next   = row_sum_reg;
        mass_next      = mass_reg;
        peak_next      = peak_reg;
        if (accept)
        begin
            if (last)
            begin
                col_count_next = '0;
                row_count_next = '0;
                col_sum_next   = '0;
                row_sum_next   = '0;
                mass_next      = '0;
                peak_next      = '0;
            end
            else
            begin
                col_count_next = col_end ? '0 : col_eff + CW'(1);
                row_count_next = col_end ? row_eff + RW'(1) : row_eff;
                col_sum_next   = col_sum_new;
                row_sum_next   = row_sum_new;
                mass_next      = mass_new;
                peak_next      = peak_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            col_sum_reg   <= '0;
            row_sum_reg   <= '0;
            mass_reg      <= '0;
            peak_reg      <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            col_sum_reg   <= col_sum_next;
            row_sum_reg   <= row_sum_next;
            mass_reg      <= mass_next;
            peak_reg      <= peak_next;
        end
    end

endmodule

// ===== hdl/bsct_back.sv =====
// ----------------------------------------------------------------------------
// Slice back end
// Takes finished slice sums from the queue, divides out the centroids and
// the paddle target on a shared serial divider, smooths the paddle
// position and holds the result until the output transaction completes.
// ----------------------------------------------------------------------------
module bsct_back #(
    parameter int MAX_HEIGHT = 64,
    parameter int HGT_W      = 7,
    parameter int MASS_W     = 23,
    parameter int CSUM_W     = 31,
    parameter int RSUM_W     = 29
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsct_pkg::cfg_t       cfg,
    input  logic [HGT_W-1:0]     height_eff,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  logic [CSUM_W-1:0]    q_col_sum,
    input  logic [RSUM_W-1:0]    q_row_sum,
    input  logic [MASS_W-1:0]    q_mass,
    input  logic [7:0]           q_peak,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bsct_pkg::result_t    result
);
    import bsct_pkg::*;

    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RP_W   = RSUM_W + 10;
    localparam int NUM_A  = CSUM_W + 8;
    localparam int NUM_B  = RP_W + 8;
    localparam int NUM_W  = (NUM_A > NUM_B) ? NUM_A : NUM_B;
    localparam int DEN_W  = MASS_W + HGT_W;
    localparam int TGT_W  = RW + 18;
    localparam int PA_W   = TGT_W + 9;
    localparam int PB_W   = 18 + 9;
    localparam int SUM_W  = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
    localparam int CMP_W  = (MASS_W > 23) ? MASS_W : 23;

    back_state_t       state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [17:0]       smooth_reg, smooth_next;
    logic [13:0]       prev_row_reg, prev_row_next;
    result_t           res_reg, res_next;

    logic [CSUM_W-1:0] col_sum_reg, col_sum_next;
    logic [RSUM_W-1:0] row_sum_reg, row_sum_next;
    logic [MASS_W-1:0] mass_reg, mass_next;
    logic [7:0]        peak_reg, peak_next;
    logic              det_reg, det_next;
    logic              motion_reg, motion_next;
    logic [15:0]       col_q_reg, col_q_next;
    logic [13:0]       row_q_reg, row_q_next;
    logic [NUM_W-1:0]  tnum_reg, tnum_next;
    logic [DEN_W-1:0]  tden_reg, tden_next;
    logic [TGT_W-1:0]  tgt_reg, tgt_next;
    logic [PA_W-1:0]   prod_a_reg, prod_a_next;
    logic [PB_W-1:0]   prod_b_reg, prod_b_next;

    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;

    logic              mass_ok;
    logic              mass_zero;
    logic [8:0]        alpha_eff;
    logic [8:0]        alpha_inv;
    logic [RP_W-1:0]   row_pr_prod;
    logic [SUM_W-1:0]  ema_sum;
    logic [13:0]       row_diff;

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    bsct_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Values derived from the latched slice and the configuration.
    always_comb
    begin
        mass_ok     = (CMP_W'(mass_reg) >= CMP_W'(cfg.min_mass));
        mass_zero   = (mass_reg == '0);
        alpha_eff   = (cfg.ema_alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_alpha_q8;
        alpha_inv   = ALPHA_ONE - alpha_eff;
        row_pr_prod = RP_W'(row_sum_reg) * RP_W'(cfg.paddle_range);
        ema_sum     = SUM_W'(prod_a_reg) + SUM_W'(prod_b_reg) + SUM_W'(Q8_ROUND);
        row_diff    = (row_q_reg > prev_row_reg) ? row_q_reg - prev_row_reg
                                                 : prev_row_reg - row_q_reg;
    end

    // Sequencer: next state, divider requests and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        smooth_next    = smooth_reg;
        prev_row_next  = prev_row_reg;
        res_next       = res_reg;
        col_sum_next   = col_sum_reg;
        row_sum_next   = row_sum_reg;
        mass_next      = mass_reg;
        peak_next      = peak_reg;
        det_next       = det_reg;
        motion_next    = motion_reg;
        col_q_next     = col_q_reg;
        row_q_next     = row_q_reg;
        tnum_next      = tnum_reg;
        tden_next      = tden_reg;
        tgt_next       = tgt_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;

        // The output register empties when its transaction completes.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    col_sum_next = q_col_sum;
                    row_sum_next = q_row_sum;
                    mass_next    = q_mass;
                    peak_next    = q_peak;
                    state_next   = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                det_next    = mass_ok;
                col_q_next  = '0;
                row_q_next  = '0;
                motion_next = 1'b0;
                tgt_next    = '0;
                if (!mass_ok)
                begin
                    state_next = BK_DONE;
                end
                else if (mass_zero)
                begin
                    // A detection with no mass smooths towards a zero target.
                    state_next = BK_EMA_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = NUM_W'({col_sum_reg, 8'd0});
                    div_den    = DEN_W'(mass_reg);
                    state_next = BK_DIV_COL;
                end
            end
            BK_DIV_COL:
            begin
                if (div_done)
                begin
                    col_q_next = div_quo[15:0];
                    div_start  = 1'b1;
                    div_num    = NUM_W'({row_sum_reg, 8'd0});
                    div_den    = DEN_W'(mass_reg);
                    state_next = BK_DIV_ROW;
                end
            end
            BK_DIV_ROW:
            begin
                if (div_done)
                begin
                    row_q_next = div_quo[13:0];
                    state_next = BK_TGT_MUL;
                end
            end
            BK_TGT_MUL:
            begin
                tnum_next  = NUM_W'({row_pr_prod, 8'd0});
                tden_next  = DEN_W'(mass_reg) * DEN_W'(height_eff);
                state_next = BK_TGT_START;
            end
            BK_TGT_START:
            begin
                div_start  = 1'b1;
                div_num    = tnum_reg;
                div_den    = tden_reg;
                state_next = BK_DIV_TGT;
            end
            BK_DIV_TGT:
            begin
                if (div_done)
                begin
                    tgt_next   = div_quo[TGT_W-1:0];
                    state_next = BK_EMA_MUL;
                end
            end
            BK_EMA_MUL:
            begin
                prod_a_next = PA_W'(alpha_eff) * PA_W'(tgt_reg);
                prod_b_next = PB_W'(alpha_inv) * PB_W'(smooth_reg);
                state_next  = BK_EMA_SUM;
            end
            BK_EMA_SUM:
            begin
                smooth_next   = ema_sum[8 +: 18];
                motion_next   = (row_diff > cfg.motion_threshold_q8);
                prev_row_next = row_q_reg;
                state_next    = BK_DONE;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_next.detected        = det_reg;
                    res_next.centroid_col_q8 = col_q_reg;
                    res_next.centroid_row_q8 = row_q_reg;
                    res_next.slice_mass      =
                        (CMP_W'(mass_reg) > CMP_W'(MASS_SAT)) ? MASS_SAT : 23'(mass_reg);
                    res_next.brightest_luma  = peak_reg;
                    res_next.paddle_pos_q8   = smooth_reg;
                    res_next.motion          = motion_reg;
                    out_valid_next           = 1'b1;
                    state_next               = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state and filter memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            smooth_reg    <= RST_SMOOTHED_POS;
            prev_row_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            smooth_reg    <= smooth_next;
            prev_row_reg  <= prev_row_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        col_sum_reg <= col_sum_next;
        row_sum_reg <= row_sum_next;
        mass_reg    <= mass_next;
        peak_reg    <= peak_next;
        det_reg     <= det_next;
        motion_reg  <= motion_next;
        col_q_reg   <= col_q_next;
        row_q_reg   <= row_q_next;
        tnum_reg    <= tnum_next;
        tden_reg    <= tden_next;
        tgt_reg     <= tgt_next;
        prod_a_reg  <= prod_a_next;
        prod_b_reg  <= prod_b_next;
    end

endmodule

// ===== hdl/bright_spot_centroid_tracker.sv =====
// ----------------------------------------------------------------------------
// Bright spot centroid tracker: takes one pixel a cycle while its slice queue has room.
// A slice with a detection and non-zero mass yields its result after three 47-step serial
// divisions; other slices skip the divider. Pixels stall while two finished slices wait.
// Reset is asynchronous and restores defaults.
// ----------------------------------------------------------------------------
module bright_spot_centroid_tracker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Pixel stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bsct_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] luma
    input  logic                               s_tuser,  // [0] frame_start
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] detected, [16:1] centroid_col_q8, [30:17] centroid_row_q8,
    // [53:31] slice_mass, [61:54] brightest_luma, [79:62] paddle_pos_q8,
    // [80] motion, [87:81] zero
    output logic [bsct_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // Configuration writes.
    input  logic                               cfg_wr_en,
    input  logic [bsct_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bsct_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bsct_pkg::*;

    localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int MASS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT * 256 + 1);
    localparam int CSUM_W  = MASS_W + CW;
    localparam int RSUM_W  = MASS_W + RW;
    localparam int ENTRY_W = CSUM_W + RSUM_W + MASS_W + 8;
    localparam int FW_CMP  = (WID_W > 9) ? WID_W : 9;
    localparam int SH_CMP  = (HGT_W > 7) ? HGT_W : 7;

    cfg_t              cfg_reg, cfg_next;
    logic [FW_CMP-1:0] fw_ext;
    logic [SH_CMP-1:0] sh_ext;
    logic [WID_W-1:0]  width_eff;
    logic [HGT_W-1:0]  height_eff;

    logic               accept;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_push_data;
    logic [ENTRY_W-1:0] q_pop_data;
    logic [CSUM_W-1:0]  f_col_sum;
    logic [RSUM_W-1:0]  f_row_sum;
    logic [MASS_W-1:0]  f_mass;
    logic [7:0]         f_peak;
    result_t            res;

    // Configuration register file.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_LUMA_THRESHOLD: cfg_next.luma_threshold      = cfg_wdata[7:0];
                CFG_MIN_MASS:       cfg_next.min_mass            = cfg_wdata[22:0];
                CFG_FRAME_WIDTH:    cfg_next.frame_width         = cfg_wdata[8:0];
                CFG_SLICE_HEIGHT:   cfg_next.slice_height        = cfg_wdata[6:0];
                CFG_PADDLE_RANGE:   cfg_next.paddle_range        = cfg_wdata[9:0];
                CFG_EMA_ALPHA:      cfg_next.ema_alpha_q8        = cfg_wdata[8:0];
                CFG_MOTION_THRESH:  cfg_next.motion_threshold_q8 = cfg_wdata[13:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.luma_threshold      <= RST_LUMA_THRESHOLD;
            cfg_reg.min_mass            <= RST_MIN_MASS;
            cfg_reg.frame_width         <= RST_FRAME_WIDTH;
            cfg_reg.slice_height        <= RST_SLICE_HEIGHT;
            cfg_reg.paddle_range        <= RST_PADDLE_RANGE;
            cfg_reg.ema_alpha_q8        <= RST_EMA_ALPHA;
            cfg_reg.motion_threshold_q8 <= RST_MOTION_THRESH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Frame dimensions clamped to the supported range.
    always_comb
    begin
        fw_ext = FW_CMP'(cfg_reg.frame_width);
        sh_ext = SH_CMP'(cfg_reg.slice_height);
        if (fw_ext == '0)
        begin
            width_eff = WID_W'(1);
        end
        else if (fw_ext > FW_CMP'(MAX_WIDTH))
        begin
            width_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WID_W'(fw_ext);
        end
        if (sh_ext == '0)
        begin
            height_eff = HGT_W'(1);
        end
        else if (sh_ext > SH_CMP'(MAX_HEIGHT))
        begin
            height_eff = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = HGT_W'(sh_ext);
        end
    end

    // Pixels stall only when the queue has no room for a finished slice.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    bsct_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WID_W      (WID_W),
        .HGT_W      (HGT_W),
        .MASS_W     (MASS_W),
        .CSUM_W     (CSUM_W),
        .RSUM_W     (RSUM_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .luma_threshold (cfg_reg.luma_threshold),
        .width_eff      (width_eff),
        .height_eff     (height_eff),
        .accept         (accept),
        .luma           (s_tdata[7:0]),
        .frame_start    (s_tuser),
        .push           (q_push),
        .push_col_sum   (f_col_sum),
        .push_row_sum   (f_row_sum),
        .push_mass      (f_mass),
        .push_peak      (f_peak)
    );

    assign q_push_data = {f_col_sum, f_row_sum, f_mass, f_peak};

    bsct_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    bsct_back #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .HGT_W      (HGT_W),
        .MASS_W     (MASS_W),
        .CSUM_W     (CSUM_W),
        .RSUM_W     (RSUM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .height_eff (height_eff),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_col_sum  (q_pop_data[ENTRY_W-1 -: CSUM_W]),
        .q_row_sum  (q_pop_data[MASS_W+8 +: RSUM_W]),
        .q_mass     (q_pop_data[8 +: MASS_W]),
        .q_peak     (q_pop_data[7:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (res)
    );

    // Result fields packed from the lowest bit up.
    assign m_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                      res.motion,
                      res.paddle_pos_q8,
                      res.brightest_luma,
                      res.slice_mass,
                      res.centroid_row_q8,
                      res.centroid_col_q8,
                      res.detected};

endmodule

// ===== hdl/bsct_checker.sv =====
// ----------------------------------------------------------------------------
// Bright spot centroid tracker checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "bright_spot_centroid_tracker_defines.svh"

module bsct_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [bsct_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import bsct_pkg::*;

    // A stalled result transaction keeps its payload.
    `BSCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // No result can be ready in the first cycle after reset.
    `BSCT_ASSERT_SAME(a_no_early_result, $rose(rst_n), !m_tvalid, "result shown straight after reset")

    // Without a detection the centroids and the motion flag are zero.
    `BSCT_ASSERT_SAME(a_undetected_zero, m_tvalid && !m_tdata[0], (m_tdata[30:1] == '0) && !m_tdata[80], "undetected result carries centroid or motion")

    // A detection with no mass reports zero centroids.
    `BSCT_ASSERT_SAME(a_zero_mass_centroid, m_tvalid && m_tdata[0] && (m_tdata[53:31] == '0), m_tdata[30:1] == '0, "zero mass result carries centroid")

endmodule

bind bright_spot_centroid_tracker bsct_checker u_bsct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
